// ===== sv/bce_pkg.sv =====
// Shared constants and types for the Bezier curve evaluator.
package bce_pkg;

    localparam int MAX_POINTS = 64;
    localparam int SAMPLES    = 256;
    localparam int SAMPLE_LAST = SAMPLES - 1;

    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int COUNT_W  = 7;
    localparam int SAMPLE_W = 8;
    localparam int COORD_W  = 16;
    localparam int EXTRA_BITS = 16;
    localparam int WORK_W   = COORD_W + EXTRA_BITS;
    localparam int T_BITS   = 24;
    localparam int T_W      = T_BITS + 1;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 40;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_EVAL  = 1'b1
    } kind_t;

endpackage

// ===== sv/bce_tdiv.sv =====
// Constant-reciprocal unit that turns a sample index into the curve parameter t.
module bce_tdiv (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [bce_pkg::SAMPLE_W-1:0]   sample,
    output logic [bce_pkg::T_W-1:0]        t_value,
    output logic                           done
);

    // The parameter is i * T_QUOT + floor((i * T_REM + LAST / 2) / LAST), where the
    // small quotient is an exact multiply by a rounded-up reciprocal.
    localparam int SMALL_W = 20;
    localparam int SHIFT   = SMALL_W + $clog2(bce_pkg::SAMPLE_LAST);
    localparam int RECIP_W = SMALL_W + 2;
    localparam int PROD_W  = SMALL_W + RECIP_W;
    localparam longint ONE_T = longint'(1) << bce_pkg::T_BITS;
    localparam longint RECIP_L =
        ((longint'(1) << SHIFT) + bce_pkg::SAMPLE_LAST - 1) / bce_pkg::SAMPLE_LAST;
    localparam logic [bce_pkg::T_W-1:0] T_QUOT = bce_pkg::T_W'(ONE_T / bce_pkg::SAMPLE_LAST);
    localparam logic [SMALL_W-1:0] T_REM = SMALL_W'(ONE_T % bce_pkg::SAMPLE_LAST);
    localparam logic [SMALL_W-1:0] HALF  = SMALL_W'(bce_pkg::SAMPLE_LAST / 2);
    localparam logic [PROD_W-1:0]  RECIP = PROD_W'(RECIP_L);

    logic [SMALL_W-1:0]            small_num;
    logic [PROD_W-1:0]             small_prod;
    logic [bce_pkg::T_W-1:0]       t_reg, t_next;
    logic                          done_reg;

    always_comb begin
        small_num  = SMALL_W'(sample) * T_REM + HALF;
        small_prod = PROD_W'(small_num) * RECIP;
        t_next     = bce_pkg::T_W'(sample) * T_QUOT + bce_pkg::T_W'(small_prod >> SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
        if (start) begin
            t_reg <= t_next;
        end
    end

    assign t_value = t_reg;
    assign done    = done_reg;

endmodule

// ===== sv/bce_lerp.sv =====
// Shared two-stage interpolation unit computing a + round((b - a) * t).
module bce_lerp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic signed [bce_pkg::WORK_W-1:0] a_in,
    input  logic signed [bce_pkg::WORK_W-1:0] b_in,
    input  logic [bce_pkg::T_W-1:0]         t_in,
    output logic                            out_valid,
    output logic signed [bce_pkg::WORK_W-1:0] result
);

    localparam int DIFF_W = bce_pkg::WORK_W + 1;
    localparam int PROD_W = DIFF_W + bce_pkg::T_W + 1;

    logic signed [DIFF_W-1:0]          diff_reg;
    logic signed [bce_pkg::WORK_W-1:0] a1_reg, a2_reg;
    logic [bce_pkg::T_W-1:0]           t1_reg;
    logic signed [PROD_W-1:0]          prod_reg;
    logic                              v1_reg, v2_reg;
    logic signed [PROD_W-1:0]          rounded;
    logic signed [PROD_W-1:0]          shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
        diff_reg <= DIFF_W'(b_in) - DIFF_W'(a_in);
        a1_reg   <= a_in;
        t1_reg   <= t_in;
        prod_reg <= PROD_W'(diff_reg) * PROD_W'($signed({1'b0, t1_reg}));
        a2_reg   <= a1_reg;
    end

    always_comb begin
        rounded = prod_reg + (PROD_W'(1) <<< (bce_pkg::T_BITS - 1));
        shifted = rounded >>> bce_pkg::T_BITS;
        result  = a2_reg + shifted[bce_pkg::WORK_W-1:0];
    end

    assign out_valid = v2_reg;

endmodule

// ===== sv/bezier_curve_evaluator_unit.sv =====
// Top level of the Bezier curve evaluator: point store, work memory and sequencer.
//
//  Channel | Direction | Fields
//  s_      | in        | tuser: kind; tdata: point_index, point_x, point_y, point_count,
//          |           |   sample_index
//  m_      | out       | tdata: sample_x, sample_y, sample_number
//
// A write word leaves the input ready.
// An evaluate word with n points (n >= 1) holds s_tready low through the parameter division,
// the point copy and the de Casteljau steps on the shared interpolation unit, once for x and
// once for y; a count of zero skips these, and both wait for a free output register.
// Reset clears the sequencer and the output valid; control points are undefined until written.
// A finished result waits in the output register while the next word is taken.
module bezier_curve_evaluator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // point_index[5:0], point_x[21:6], point_y[37:22], point_count[44:38],
    // sample_index[52:45], zero fill above
    input  logic [bce_pkg::S_DATA_W-1:0]  s_tdata,
    // kind[0]
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // sample_x[15:0], sample_y[31:16], sample_number[39:32]
    output logic [bce_pkg::M_DATA_W-1:0]  m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_COPY_RD, ST_COPY_WR, ST_LV_RD0, ST_LV_A,
        ST_LV_RDB, ST_LV_B, ST_LV_WAIT, ST_FIN_RD, ST_FIN, ST_OUT
    } state_t;

    localparam int IW = bce_pkg::IDX_W;
    localparam int CW = bce_pkg::COUNT_W;
    localparam int WW = bce_pkg::WORK_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(bce_pkg::MAX_POINTS);
    localparam logic [bce_pkg::SAMPLE_W:0] LAST_EXT = (bce_pkg::SAMPLE_W + 1)'(bce_pkg::SAMPLE_LAST);

    logic [IW-1:0]                 in_index;
    logic [bce_pkg::COORD_W-1:0]   in_x, in_y;
    logic [CW-1:0]                 in_count;
    logic [bce_pkg::SAMPLE_W-1:0]  in_sample, clamp_sample;
    logic                          s_accept;

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 level_reg, level_next;
    logic [CW-1:0]                 k_reg, k_next;
    logic                          coord_reg, coord_next;
    logic [bce_pkg::SAMPLE_W-1:0]  sample_reg, sample_next;
    logic [bce_pkg::COORD_W-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [WW-1:0]          a_reg, a_next;
    logic                          m_tvalid_reg;
    logic [bce_pkg::M_DATA_W-1:0]  m_tdata_reg;

    logic [31:0]                   cp_mem [bce_pkg::MAX_POINTS];
    logic [31:0]                   cp_q;
    logic [IW-1:0]                 cp_rd_addr;
    logic signed [WW-1:0]          w_mem [bce_pkg::MAX_POINTS];
    logic signed [WW-1:0]          w_q;
    logic [IW-1:0]                 w_rd_addr, w_wr_addr;
    logic                          w_wr_en;
    logic signed [WW-1:0]          w_wr_data;

    logic                          div_start;
    logic [bce_pkg::T_W-1:0]       t_value;
    logic                          div_done;
    logic                          lerp_start;
    logic                          lerp_valid;
    logic signed [WW-1:0]          lerp_result;
    logic [bce_pkg::COORD_W-1:0]   cp_coord;
    logic signed [WW:0]            fin_sum;
    logic [bce_pkg::COORD_W-1:0]   fin_coord;
    logic                          out_free;

    assign in_index  = s_tdata[5:0];
    assign in_x      = s_tdata[21:6];
    assign in_y      = s_tdata[37:22];
    assign in_count  = s_tdata[44:38];
    assign in_sample = s_tdata[52:45];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign clamp_sample = ({1'b0, in_sample} > LAST_EXT) ?
                          bce_pkg::SAMPLE_W'(bce_pkg::SAMPLE_LAST) : in_sample;

    assign cp_coord  = coord_reg ? cp_q[31:16] : cp_q[15:0];
    assign fin_sum   = (WW + 1)'(w_q) + (WW + 1)'(1 << (bce_pkg::EXTRA_BITS - 1));
    assign fin_coord = fin_sum[bce_pkg::EXTRA_BITS +: bce_pkg::COORD_W];
    assign out_free  = !m_tvalid_reg || m_tready;

    bce_tdiv u_tdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sample  (clamp_sample),
        .t_value (t_value),
        .done    (div_done)
    );

    bce_lerp u_lerp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (lerp_start),
        .a_in      (a_reg),
        .b_in      (w_q),
        .t_in      (t_value),
        .out_valid (lerp_valid),
        .result    (lerp_result)
    );

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        level_next  = level_reg;
        k_next      = k_reg;
        coord_next  = coord_reg;
        sample_next = sample_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        a_next      = a_reg;
        div_start   = 1'b0;
        lerp_start  = 1'b0;
        cp_rd_addr  = k_reg[IW-1:0];
        w_rd_addr   = k_reg[IW-1:0];
        w_wr_en     = 1'b0;
        w_wr_addr   = k_reg[IW-1:0];
        w_wr_data   = lerp_result;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (bce_pkg::kind_t'(s_tuser[0]) == bce_pkg::KIND_EVAL)) begin
                    sample_next = in_sample;
                    count_next  = (in_count > MAX_COUNT) ? MAX_COUNT : in_count;
                    coord_next  = 1'b0;
                    k_next      = '0;
                    if (in_count == '0) begin
                        x_next     = '0;
                        y_next     = '0;
                        state_next = ST_OUT;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_COPY_RD: begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                w_wr_en   = 1'b1;
                w_wr_data = WW'({cp_coord, {bce_pkg::EXTRA_BITS{1'b0}}});
                if (k_reg == count_reg - 1'b1) begin
                    level_next = count_reg - 1'b1;
                    state_next = (count_reg == CW'(1)) ? ST_FIN_RD : ST_LV_RD0;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_COPY_RD;
                end
            end
            ST_LV_RD0: begin
                w_rd_addr  = '0;
                state_next = ST_LV_A;
            end
            ST_LV_A: begin
                a_next     = w_q;
                k_next     = CW'(1);
                state_next = ST_LV_RDB;
            end
            ST_LV_RDB: begin
                state_next = ST_LV_B;
            end
            ST_LV_B: begin
                lerp_start = 1'b1;
                a_next     = w_q;
                state_next = ST_LV_WAIT;
            end
            ST_LV_WAIT: begin
                if (lerp_valid) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = IW'(k_reg - 1'b1);
                    if (k_reg == level_reg) begin
                        level_next = level_reg - 1'b1;
                        state_next = (level_reg == CW'(1)) ? ST_FIN_RD : ST_LV_RD0;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_LV_RDB;
                    end
                end
            end
            ST_FIN_RD: begin
                w_rd_addr  = '0;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (coord_reg) begin
                    y_next     = fin_coord;
                    state_next = ST_OUT;
                end else begin
                    x_next     = fin_coord;
                    coord_next = 1'b1;
                    k_next     = '0;
                    state_next = ST_COPY_RD;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {sample_reg, y_reg, x_reg};
        end
        count_reg  <= count_next;
        level_reg  <= level_next;
        k_reg      <= k_next;
        coord_reg  <= coord_next;
        sample_reg <= sample_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        a_reg      <= a_next;
    end

    always_ff @(posedge aclk) begin
        if (s_accept && (bce_pkg::kind_t'(s_tuser[0]) == bce_pkg::KIND_WRITE)) begin
            cp_mem[in_index] <= {in_y, in_x};
        end
        cp_q <= cp_mem[cp_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (w_wr_en) begin
            w_mem[w_wr_addr] <= w_wr_data;
        end
        w_q <= w_mem[w_rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/bce_checker.sv =====
// Port-level checks for the Bezier curve evaluator and their binding.
module bce_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [0:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bce_pkg::M_DATA_W-1:0]  m_tdata
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output word valid right after reset.");

    a_eval_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
        else $error("Input still ready after an evaluate word.");

    a_write_keeps_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser[0]) |=> s_tready)
        else $error("Input stalled after a write word.");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("Stalled output word changed.");

endmodule

bind bezier_curve_evaluator_unit bce_checker u_bce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
